FILE: src/kmp_substring_matcher_defines.svh
// Assertion macros for the KMP substring matcher RTL.
// No dependencies; included by modules that carry concurrent checks.
`ifndef KMP_SUBSTRING_MATCHER_DEFINES_SVH
`define KMP_SUBSTRING_MATCHER_DEFINES_SVH

`ifndef NO_ASSERTIONS

// Clocked check, disabled while the reset is high
`define KMP_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Clocked check that also holds during reset
`define KMP_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`else

`define KMP_ASSERT(lbl, clk, rst, prop, msg)
`define KMP_ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

FILE: src/kmp_pkg.sv
// Sizing constants for the KMP substring matcher.
// No dependencies; imported by kmp_substring_matcher.
`timescale 1ns / 1ps

package kmp_pkg;

   localparam int MAX_PATTERN = 256;
   localparam int MAX_TEXT    = 65536;

   // pattern store address and length widths (length reaches MAX_PATTERN)
   localparam int PAT_AW = $clog2(MAX_PATTERN);
   localparam int PLEN_W = PAT_AW + 1;

   // text position counts up to MAX_TEXT inclusive
   localparam int TPOS_W = $clog2(MAX_TEXT) + 1;

   localparam int SYM_W  = 8;
   localparam int POS_W  = 16;

   // working width for text_position - pattern_length
   localparam int DIFF_W0 = (TPOS_W > PLEN_W) ? TPOS_W : PLEN_W;
   localparam int DIFF_W  = (DIFF_W0 > POS_W) ? DIFF_W0 : POS_W;

   // action codes
   localparam logic ACT_PATTERN = 1'b0;
   localparam logic ACT_TEXT    = 1'b1;

endpackage

FILE: src/kmp_substring_matcher.sv
// KMP substring matcher: online failure-table build and text search.
// Depends on kmp_pkg and kmp_substring_matcher_defines.svh.
`timescale 1ns / 1ps
`include "kmp_substring_matcher_defines.svh"

// Usage
//  Request: drive req_action/req_symbol/req_last and pulse start while busy is
//    low; the transfer happens on that edge. action 0 = pattern byte,
//    action 1 = text byte, last marks the final byte of pattern or text.
//  Response: on the final text byte one result comes out, rsp_valid high for
//    exactly one cycle with rsp_found, rsp_position, rsp_too_long. The receiver
//    cannot stall; the result must be taken in that cycle.
//  Timing: one shared compare loop over two RAMs with a write and a read port
//    each (pattern bytes, failure links). A fallback step is a failure read,
//    then a pattern read and compare. The first pattern byte is written from
//    idle; other pattern bytes start with a failure read, text bytes with a
//    pattern read, and an ignored text byte stays idle. The result is
//    registered and shows in the cycle after the final text byte is done.
//  busy is high while a byte is in S_FAIL or S_SYM; no byte is taken then.
//  Reset (synchronous, active high): clears pattern length, text state and
//    the overflow flag; RAM contents are left as they were.
module kmp_substring_matcher (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   output logic                      busy,
   input  logic                      req_action,
   input  logic [kmp_pkg::SYM_W-1:0] req_symbol,
   input  logic                      req_last,
   output logic                      rsp_valid,
   output logic                      rsp_found,
   output logic [kmp_pkg::POS_W-1:0] rsp_position,
   output logic                      rsp_too_long
);
   import kmp_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE = 3'b001,   // waiting for a transfer
      S_FAIL = 3'b010,   // failure link read data valid
      S_SYM  = 3'b100    // pattern byte read data valid, compare
   } state_type;

   state_type state_ff, state_in;

   // architectural state
   logic [PLEN_W-1:0] len_ff, len_in;
   logic [PLEN_W-1:0] midx_ff, midx_in;
   logic [TPOS_W-1:0] tpos_ff, tpos_in;
   logic              mdone_ff, mdone_in;
   logic              ovf_ff, ovf_in;
   logic              pat_done_ff, pat_done_in;

   // current item and walk pointer
   logic [SYM_W-1:0]  sym_ff, sym_in;
   logic              last_ff, last_in;
   logic              txt_ff, txt_in;
   logic [PLEN_W-1:0] k_ff, k_in;

   // result register
   logic              rsp_valid_ff, rsp_valid_in;
   logic              rsp_found_ff, rsp_found_in;
   logic [POS_W-1:0]  rsp_pos_ff, rsp_pos_in;
   logic              rsp_tl_ff, rsp_tl_in;

   // memories
   logic [SYM_W-1:0]  pstore [MAX_PATTERN];
   logic [PLEN_W-1:0] fail_mem [MAX_PATTERN];
   logic [SYM_W-1:0]  pstore_q;
   logic [PLEN_W-1:0] fail_q;
   logic              p_we, f_we;
   logic [PAT_AW-1:0] p_waddr, p_raddr, f_waddr, f_raddr;
   logic [PLEN_W-1:0] f_wdata;

   // helpers
   logic              accept;
   logic [PLEN_W-1:0] len_base;
   logic              ovf_base;
   logic [PLEN_W-1:0] len_base_m1;
   logic [PLEN_W-1:0] k_m1;
   logic              sym_eq;
   logic [PLEN_W-1:0] k_next;
   logic [TPOS_W-1:0] tpos_inc;
   logic [DIFF_W-1:0] diff_idle, diff_sym;

   assign accept      = start && (state_ff == S_IDLE);
   assign len_base    = pat_done_ff ? '0 : len_ff;
   assign ovf_base    = pat_done_ff ? 1'b0 : ovf_ff;
   assign len_base_m1 = len_base - 1'b1;
   assign k_m1        = k_ff - 1'b1;
   assign sym_eq      = (pstore_q == sym_ff);
   assign k_next      = k_ff + PLEN_W'(sym_eq);
   assign tpos_inc    = tpos_ff + 1'b1;
   assign diff_idle   = DIFF_W'(tpos_ff) - DIFF_W'(len_ff);
   assign diff_sym    = DIFF_W'(tpos_inc) - DIFF_W'(len_ff);

   always_comb begin
      state_in     = state_ff;
      len_in       = len_ff;
      midx_in      = midx_ff;
      tpos_in      = tpos_ff;
      mdone_in     = mdone_ff;
      ovf_in       = ovf_ff;
      pat_done_in  = pat_done_ff;
      sym_in       = sym_ff;
      last_in      = last_ff;
      txt_in       = txt_ff;
      k_in         = k_ff;
      rsp_valid_in = 1'b0;
      rsp_found_in = rsp_found_ff;
      rsp_pos_in   = rsp_pos_ff;
      rsp_tl_in    = rsp_tl_ff;
      p_we         = 1'b0;
      p_waddr      = len_base[PAT_AW-1:0];
      p_raddr      = k_ff[PAT_AW-1:0];
      f_we         = 1'b0;
      f_waddr      = len_ff[PAT_AW-1:0];
      f_wdata      = k_next;
      f_raddr      = k_m1[PAT_AW-1:0];

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               sym_in  = req_symbol;
               last_in = req_last;
               txt_in  = req_action;
               if (req_action == ACT_PATTERN) begin
                  // a pattern byte after a closed pattern starts over
                  if (pat_done_ff) begin
                     midx_in  = '0;
                     tpos_in  = '0;
                     mdone_in = 1'b0;
                  end
                  pat_done_in = req_last;
                  len_in      = len_base;
                  ovf_in      = ovf_base;
                  if (len_base >= PLEN_W'(MAX_PATTERN)) begin
                     ovf_in = 1'b1;
                  end else begin
                     p_we = 1'b1;
                     if (len_base == '0) begin
                        f_we    = 1'b1;
                        f_waddr = '0;
                        f_wdata = '0;
                        len_in  = PLEN_W'(1);
                     end else begin
                        f_raddr  = len_base_m1[PAT_AW-1:0];
                        state_in = S_FAIL;
                     end
                  end
               end else begin
                  pat_done_in = 1'b1;
                  if (mdone_ff) begin
                     // bytes after the first match are ignored
                  end else if (len_ff == '0) begin
                     mdone_in = 1'b1;       // empty pattern matches at 0
                  end else if (tpos_ff >= TPOS_W'(MAX_TEXT)) begin
                     ovf_in = 1'b1;
                  end else begin
                     k_in     = midx_ff;
                     p_raddr  = midx_ff[PAT_AW-1:0];
                     state_in = S_SYM;
                  end
                  if (req_last && state_in == S_IDLE) begin
                     rsp_valid_in = 1'b1;
                     rsp_found_in = mdone_in;
                     rsp_pos_in   = mdone_in ? diff_idle[POS_W-1:0] : '0;
                     rsp_tl_in    = ovf_in;
                     midx_in      = '0;
                     tpos_in      = '0;
                     mdone_in     = 1'b0;
                  end
               end
            end
         end
         S_FAIL: begin
            k_in     = fail_q;
            p_raddr  = fail_q[PAT_AW-1:0];
            state_in = S_SYM;
         end
         S_SYM: begin
            if (k_ff != '0 && !sym_eq) begin
               // fall back one link
               f_raddr  = k_m1[PAT_AW-1:0];
               state_in = S_FAIL;
            end else begin
               state_in = S_IDLE;
               if (txt_ff == ACT_PATTERN) begin
                  f_we    = 1'b1;
                  f_waddr = len_ff[PAT_AW-1:0];
                  f_wdata = k_next;
                  len_in  = len_ff + 1'b1;
               end else begin
                  tpos_in = tpos_inc;
                  if (k_next >= len_ff) begin
                     mdone_in = 1'b1;
                     midx_in  = '0;
                  end else begin
                     midx_in = k_next;
                  end
                  if (last_ff) begin
                     rsp_valid_in = 1'b1;
                     rsp_found_in = mdone_in;
                     rsp_pos_in   = mdone_in ? diff_sym[POS_W-1:0] : '0;
                     rsp_tl_in    = ovf_ff;
                     midx_in      = '0;
                     tpos_in      = '0;
                     mdone_in     = 1'b0;
                  end
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         len_ff       <= '0;
         midx_ff      <= '0;
         tpos_ff      <= '0;
         mdone_ff     <= 1'b0;
         ovf_ff       <= 1'b0;
         pat_done_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         len_ff       <= len_in;
         midx_ff      <= midx_in;
         tpos_ff      <= tpos_in;
         mdone_ff     <= mdone_in;
         ovf_ff       <= ovf_in;
         pat_done_ff  <= pat_done_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      sym_ff       <= sym_in;
      last_ff      <= last_in;
      txt_ff       <= txt_in;
      k_ff         <= k_in;
      rsp_found_ff <= rsp_found_in;
      rsp_pos_ff   <= rsp_pos_in;
      rsp_tl_ff    <= rsp_tl_in;
   end

   // pattern byte RAM
   always_ff @(posedge clock) begin
      if (p_we) begin
         pstore[p_waddr] <= sym_in;
      end
      pstore_q <= pstore[p_raddr];
   end

   // failure link RAM
   always_ff @(posedge clock) begin
      if (f_we) begin
         fail_mem[f_waddr] <= f_wdata;
      end
      fail_q <= fail_mem[f_raddr];
   end

   assign busy         = (state_ff != S_IDLE);
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_found    = rsp_found_ff;
   assign rsp_position = rsp_pos_ff;
   assign rsp_too_long = rsp_tl_ff;

   `KMP_ASSERT(a_walk_below_len, clock, reset, (state_ff == S_SYM) |-> (k_ff < len_ff), "walk pointer not below pattern length")
   `KMP_ASSERT(a_midx_below_len, clock, reset, (midx_ff == '0) || (midx_ff < len_ff), "match index not below pattern length")
   `KMP_ASSERT(a_len_bound, clock, reset, len_ff <= PLEN_W'(MAX_PATTERN), "pattern length beyond bound")
   `KMP_ASSERT(a_miss_pos_zero, clock, reset, (rsp_valid && !rsp_found) |-> (rsp_position == '0), "nonzero position on a miss")

endmodule

FILE: sim/kmp_substring_matcher_tb.sv
// Self-checking testbench for kmp_substring_matcher: directed table, then random traffic.
// Depends on kmp_pkg and the matcher RTL; carries its own search predictor.
`timescale 1ns / 1ps

module kmp_substring_matcher_tb;
   import kmp_pkg::*;

   localparam int unsigned RANDOM_BYTES  = 1100;
   localparam int unsigned IDLE_LIMIT    = 5000;  // cycles with no transfer at all
   localparam int unsigned DRAIN_CYCLES  = 20;
   localparam int unsigned MAX_WORD      = 16;
   localparam int unsigned NUM_DIRECTED  = 26;

   typedef struct packed {
      logic             found;
      logic [POS_W-1:0] position;
      logic             too_long;
   } search_result_type;

   // one table row: a byte sent count times, last only on the final copy
   typedef struct packed {
      logic              action;
      logic [SYM_W-1:0]  symbol;
      logic              last;
      int unsigned       count;
      bit                pinned;
      search_result_type want;
   } stim_row_type;

   localparam search_result_type NONE = '0;

   localparam stim_row_type DIRECTED [NUM_DIRECTED] = '{
      // empty pattern right after reset matches at 0
      '{ACT_TEXT,    "a",   1'b1, 1,     1'b1, '{1'b1, 16'd0,     1'b0}},
      '{ACT_PATTERN, "a",   1'b0, 1,     1'b0, NONE},
      '{ACT_PATTERN, "b",   1'b1, 1,     1'b0, NONE},
      '{ACT_TEXT,    "x",   1'b0, 1,     1'b0, NONE},
      '{ACT_TEXT,    "a",   1'b0, 1,     1'b0, NONE},
      '{ACT_TEXT,    "b",   1'b1, 1,     1'b1, '{1'b1, 16'd1,     1'b0}},
      // "aab" in "aaab": one fallback, trailing bytes ignored after the hit
      '{ACT_PATTERN, "a",   1'b0, 2,     1'b0, NONE},
      '{ACT_PATTERN, "b",   1'b1, 1,     1'b0, NONE},
      '{ACT_TEXT,    "a",   1'b0, 3,     1'b0, NONE},
      '{ACT_TEXT,    "b",   1'b0, 1,     1'b0, NONE},
      '{ACT_TEXT,    "q",   1'b1, 2,     1'b1, '{1'b1, 16'd1,     1'b0}},
      // text arrives before the pattern was closed
      '{ACT_PATTERN, "q",   1'b0, 1,     1'b0, NONE},
      '{ACT_TEXT,    "q",   1'b1, 1,     1'b1, '{1'b1, 16'd0,     1'b0}},
      // symbol extremes
      '{ACT_PATTERN, 8'h00, 1'b0, 1,     1'b0, NONE},
      '{ACT_PATTERN, 8'hFF, 1'b1, 1,     1'b0, NONE},
      '{ACT_TEXT,    8'hFF, 1'b0, 1,     1'b0, NONE},
      '{ACT_TEXT,    8'h00, 1'b0, 1,     1'b0, NONE},
      '{ACT_TEXT,    8'hFF, 1'b1, 1,     1'b1, '{1'b1, 16'd1,     1'b0}},
      // pattern overflow: flag sticks across texts until a new pattern
      '{ACT_PATTERN, "c",   1'b1, 300,   1'b0, NONE},
      '{ACT_TEXT,    "c",   1'b1, 256,   1'b1, '{1'b1, 16'd0,     1'b1}},
      '{ACT_TEXT,    "d",   1'b1, 1,     1'b1, '{1'b0, 16'd0,     1'b1}},
      // new pattern clears the flag; hit after a run of misses, tail ignored
      '{ACT_PATTERN, "y",   1'b1, 1,     1'b0, NONE},
      '{ACT_TEXT,    "z",   1'b0, 5,     1'b0, NONE},
      '{ACT_TEXT,    "y",   1'b0, 1,     1'b0, NONE},
      '{ACT_TEXT,    "z",   1'b1, 3,     1'b1, '{1'b1, 16'd5,     1'b0}},
      // plain miss
      '{ACT_TEXT,    "z",   1'b1, 1,     1'b1, '{1'b0, 16'd0,     1'b0}}
   };

   logic             clock;
   logic             reset;
   logic             start;
   logic             busy;
   logic             req_action;
   logic [SYM_W-1:0] req_symbol;
   logic             req_last;
   logic             rsp_valid;
   logic             rsp_found;
   logic [POS_W-1:0] rsp_position;
   logic             rsp_too_long;

   kmp_substring_matcher DUT (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .busy         (busy),
      .req_action   (req_action),
      .req_symbol   (req_symbol),
      .req_last     (req_last),
      .rsp_valid    (rsp_valid),
      .rsp_found    (rsp_found),
      .rsp_position (rsp_position),
      .rsp_too_long (rsp_too_long)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // predictor state
   logic [SYM_W-1:0] pat_mem [MAX_PATTERN];
   int unsigned      border_len [MAX_PATTERN];
   int unsigned      pat_len;
   int unsigned      cmp_idx;
   int unsigned      text_cnt;
   bit               hit_seen;
   bit               trunc_seen;
   bit               pat_closed;

   search_result_type pending_results [$];
   search_result_type front_res;
   int unsigned       mismatch_cnt;
   int unsigned       idle_cycles;
   int unsigned       burst_left;
   int unsigned       bytes_sent;

   // advance the search state by one byte; a final text byte yields a result
   task automatic kmp_predict(input logic act, input logic [SYM_W-1:0] sym, input logic lst,
                              output bit has_res, output search_result_type res);
      int unsigned k;
      has_res = 1'b0;
      res     = '0;
      if (act == ACT_PATTERN) begin
         if (pat_closed) begin
            pat_len    = 0;
            cmp_idx    = 0;
            text_cnt   = 0;
            hit_seen   = 1'b0;
            trunc_seen = 1'b0;
            pat_closed = 1'b0;
         end
         if (pat_len >= MAX_PATTERN) begin
            trunc_seen = 1'b1;
         end else begin
            pat_mem[pat_len] = sym;
            if (pat_len == 0) begin
               border_len[0] = 0;
            end else begin
               k = border_len[pat_len-1];
               while (k > 0 && pat_mem[k] != sym)
                  k = border_len[k-1];
               if (pat_mem[k] == sym)
                  k++;
               border_len[pat_len] = k;
            end
            pat_len++;
         end
         if (lst)
            pat_closed = 1'b1;
      end else begin
         pat_closed = 1'b1;
         if (!hit_seen) begin
            if (pat_len == 0) begin
               hit_seen = 1'b1;
            end else if (text_cnt >= MAX_TEXT) begin
               trunc_seen = 1'b1;
            end else begin
               k = cmp_idx;
               while (k > 0 && pat_mem[k] != sym)
                  k = border_len[k-1];
               if (pat_mem[k] == sym)
                  k++;
               text_cnt++;
               if (k >= pat_len) begin
                  hit_seen = 1'b1;
                  k = 0;
               end
               cmp_idx = k;
            end
         end
         if (lst) begin
            has_res          = 1'b1;
            res.found        = hit_seen;
            res.position     = hit_seen ? POS_W'(text_cnt - pat_len) : '0;
            res.too_long     = trunc_seen;
            cmp_idx          = 0;
            text_cnt         = 0;
            hit_seen         = 1'b0;
         end
      end
   endtask

   // one byte transfer, paced in bursts; pinned rows queue their typed result
   task automatic send_byte(input logic act, input logic [SYM_W-1:0] sym, input logic lst,
                            input bit pinned, input search_result_type pinned_res);
      int unsigned       gap;
      bit                has_res;
      search_result_type res;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 32);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         repeat (gap) begin
            @(negedge clock);
            start <= 1'b0;
         end
      end
      burst_left--;
      @(negedge clock);
      start      <= 1'b1;
      req_action <= act;
      req_symbol <= sym;
      req_last   <= lst;
      do
         @(posedge clock);
      while (busy);
      bytes_sent++;
      kmp_predict(act, sym, lst, has_res, res);
      if (has_res)
         pending_results.push_back(pinned ? pinned_res : res);
   endtask

   // mostly well-formed pattern/text sessions over a narrow alphabet, some noise
   task automatic random_traffic(input int unsigned quota);
      logic [SYM_W-1:0] word [MAX_WORD];
      logic [SYM_W-1:0] base;
      logic [SYM_W-1:0] sym;
      int unsigned      span, plen, ntexts, tlen, at, i, t, stop_at;
      bit               close_early;
      stop_at = bytes_sent + quota;
      while (bytes_sent < stop_at) begin
         if ($urandom_range(0, 4) == 0) begin
            repeat ($urandom_range(1, 10))
               send_byte(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                         $urandom_range(0, 3) == 0, 1'b0, NONE);
         end else begin
            base        = 8'($urandom_range(0, 255));
            span        = $urandom_range(1, 3);
            plen        = ($urandom_range(0, 9) == 0) ? $urandom_range(7, MAX_WORD)
                                                      : $urandom_range(1, 6);
            close_early = ($urandom_range(0, 6) == 0);
            for (i = 0; i < plen; i++) begin
               word[i] = base + 8'($urandom_range(0, span - 1));
               send_byte(ACT_PATTERN, word[i], (i == plen - 1) && !close_early, 1'b0, NONE);
            end
            ntexts = $urandom_range(1, 4);
            for (t = 0; t < ntexts; t++) begin
               tlen = $urandom_range(1, 24);
               // sometimes plant a copy of the pattern
               at = ($urandom_range(0, 2) == 0) ? $urandom_range(0, tlen - 1) : tlen;
               for (i = 0; i < tlen; i++) begin
                  if (i >= at && i - at < plen)
                     sym = word[i-at];
                  else
                     sym = base + 8'($urandom_range(0, span - 1));
                  send_byte(ACT_TEXT, sym, i == tlen - 1, 1'b0, NONE);
               end
            end
         end
      end
   endtask

   // result checker: every strobe pairs with the oldest prediction
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (pending_results.size() == 0) begin
            $display("%0t: result with nothing expected: found=%0b position=%0d too_long=%0b",
                     $time, rsp_found, rsp_position, rsp_too_long);
            mismatch_cnt++;
         end else begin
            front_res = pending_results.pop_front();
            if (rsp_found !== front_res.found) begin
               $display("%0t: found expected %0b, got %0b", $time, front_res.found, rsp_found);
               mismatch_cnt++;
            end
            if (rsp_position !== front_res.position) begin
               $display("%0t: position expected %0d, got %0d",
                        $time, front_res.position, rsp_position);
               mismatch_cnt++;
            end
            if (rsp_too_long !== front_res.too_long) begin
               $display("%0t: too_long expected %0b, got %0b",
                        $time, front_res.too_long, rsp_too_long);
               mismatch_cnt++;
            end
         end
      end
   end

   // watchdog: cycles with neither a byte nor a result transfer
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("%0t: no transfer for %0d cycles", $time, IDLE_LIMIT);
         $display("Regression FAIL");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      int unsigned r, n;
      reset        = 1'b1;
      start        = 1'b0;
      req_action   = ACT_PATTERN;
      req_symbol   = '0;
      req_last     = 1'b0;
      idle_cycles  = 0;
      mismatch_cnt = 0;
      burst_left   = 0;
      bytes_sent   = 0;
      pat_len      = 0;
      cmp_idx      = 0;
      text_cnt     = 0;
      hit_seen     = 1'b0;
      trunc_seen   = 1'b0;
      pat_closed   = 1'b0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (r = 0; r < NUM_DIRECTED; r++)
         for (n = 0; n < DIRECTED[r].count; n++)
            send_byte(DIRECTED[r].action, DIRECTED[r].symbol,
                      DIRECTED[r].last && (n == DIRECTED[r].count - 1),
                      DIRECTED[r].pinned && (n == DIRECTED[r].count - 1), DIRECTED[r].want);

      random_traffic(RANDOM_BYTES);

      @(negedge clock);
      start <= 1'b0;
      while (pending_results.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatch_cnt == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule

FILE: sim.f
+incdir+src
src/kmp_pkg.sv
src/kmp_substring_matcher.sv
sim/kmp_substring_matcher_tb.sv
